@@ hdl/msac_pkg.sv @@
package msac_pkg;

    typedef enum logic {
        CMD_POINT = 1'b0,
        CMD_OFFER = 1'b1
    } cmd_e;

    typedef enum logic [2:0] {
        CFG_MODE           = 3'd0,
        CFG_POINTS_COUNT   = 3'd1,
        CFG_INLIER_THR     = 3'd2,
        CFG_NORM_THR       = 3'd3,
        CFG_INV_NORM_THR   = 3'd4
    } cfg_index_e;

    typedef struct packed {
        logic        mode;
        logic [12:0] points_count;
        logic [31:0] inlier_thr;
        logic [31:0] norm_threshold;
        logic [31:0] inverse_norm_threshold;
    } cfg_t;

    // one point (or offer) after the multiply stage
    typedef struct packed {
        cmd_e               cmd;
        logic signed [29:0] offered_score;
        logic               inlier;
        logic               in_norm;
        logic [16:0]        loss_term;
    } term_t;

    localparam logic [16:0]        ONE_Q16    = 17'h10000;
    localparam logic [12:0]        TALLY_MAX  = 13'h1FFF;
    localparam logic signed [29:0] BEST_RESET = 30'sh1FFF_FFFF;
    localparam logic signed [29:0] LOSS_MIN   = 30'sh2000_0000;
    localparam logic signed [28:0] SCORE_MIN  = 29'sh1000_0000;

    localparam logic        MODE_RANSAC  = 1'b0;
    localparam logic        MODE_MSAC    = 1'b1;

    localparam logic        MODE_RESET   = MODE_MSAC;
    localparam logic [12:0] COUNT_RESET  = 13'd4096;
    localparam logic [31:0] THR_RESET    = 32'h0001_0000;

endpackage

@@ hdl/ransac_msac_hypothesis_scorer_unit.sv @@
// An accepted point beat passes the input register, the multiply stage and the
// output register before its result is on m_valid. Throughput: one beat per cycle
// while no result is stalled on m_ready. While one is, a beat that ends a model
// waits in the multiply stage, and s_ready drops once the input stage is full.
// Reset: aresetn low clears all counters and the output valid, sets the kept best
// score to its largest positive value, and loads the register defaults.
module ransac_msac_hypothesis_scorer_unit #(
    parameter int MAX_POINTS = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [31:0]        s_residual,
    input  logic signed [29:0] s_offered_score,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [12:0]        m_inlier_count,
    output logic signed [28:0] m_score,
    output logic               m_stopped_early,
    output logic [12:0]        m_points_tested
);

    msac_pkg::cfg_t  cfg;
    msac_pkg::term_t term;
    logic            term_valid;
    logic            term_ready;

    msac_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msac_term u_term (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_residual      (s_residual),
        .s_offered_score (s_offered_score),
        .cfg             (cfg),
        .term_valid      (term_valid),
        .term_ready      (term_ready),
        .term            (term)
    );

    msac_acc #(
        .MAX_POINTS (MAX_POINTS)
    ) u_acc (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .term_valid      (term_valid),
        .term_ready      (term_ready),
        .term            (term),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_inlier_count  (m_inlier_count),
        .m_score         (m_score),
        .m_stopped_early (m_stopped_early),
        .m_points_tested (m_points_tested)
    );

endmodule

@@ hdl/msac_cfg.sv @@
module msac_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output msac_pkg::cfg_t    cfg
);

    msac_pkg::cfg_t cfg_reg;
    msac_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                msac_pkg::CFG_MODE:         cfg_next.mode = cfg_data[0];
                msac_pkg::CFG_POINTS_COUNT: cfg_next.points_count = cfg_data[12:0];
                msac_pkg::CFG_INLIER_THR:   cfg_next.inlier_thr = cfg_data;
                msac_pkg::CFG_NORM_THR:     cfg_next.norm_threshold = cfg_data;
                msac_pkg::CFG_INV_NORM_THR: cfg_next.inverse_norm_threshold = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode                   <= msac_pkg::MODE_RESET;
            cfg_reg.points_count           <= msac_pkg::COUNT_RESET;
            cfg_reg.inlier_thr             <= msac_pkg::THR_RESET;
            cfg_reg.norm_threshold         <= msac_pkg::THR_RESET;
            cfg_reg.inverse_norm_threshold <= msac_pkg::THR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/msac_term.sv @@
module msac_term (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic [31:0]         s_residual,
    input  logic signed [29:0]  s_offered_score,
    input  msac_pkg::cfg_t      cfg,
    output logic                term_valid,
    input  logic                term_ready,
    output msac_pkg::term_t     term
);

    logic               in_valid_reg, in_valid_next;
    logic               in_cmd_reg;
    logic [31:0]        in_residual_reg;
    logic signed [29:0] in_offer_reg;
    logic               term_valid_reg, term_valid_next;
    msac_pkg::term_t    term_reg, term_next;

    logic               in_ready;
    logic               stage_ready;
    logic [63:0]        product;
    logic [47:0]        product_q;
    logic [16:0]        clamped;

    assign stage_ready = !term_valid_reg || term_ready;
    assign in_ready    = !in_valid_reg || stage_ready;
    assign s_ready     = in_ready;
    assign term_valid  = term_valid_reg;
    assign term        = term_reg;

    assign in_valid_next   = in_ready ? s_valid : in_valid_reg;
    assign term_valid_next = stage_ready ? in_valid_reg : term_valid_reg;

    always_comb begin
        product   = {32'h0, in_residual_reg} * {32'h0, cfg.inverse_norm_threshold};
        product_q = product[63:16];
        // hold the ratio at 1.0
        if (product_q > {31'h0, msac_pkg::ONE_Q16}) begin
            clamped = msac_pkg::ONE_Q16;
        end else begin
            clamped = product_q[16:0];
        end
        term_next.cmd           = msac_pkg::cmd_e'(in_cmd_reg);
        term_next.offered_score = in_offer_reg;
        term_next.inlier        = in_residual_reg < cfg.inlier_thr;
        term_next.in_norm       = in_residual_reg < cfg.norm_threshold;
        term_next.loss_term     = msac_pkg::ONE_Q16 - clamped;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            term_valid_reg <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            term_valid_reg <= term_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && in_ready) begin
            in_cmd_reg      <= s_cmd;
            in_residual_reg <= s_residual;
            in_offer_reg    <= s_offered_score;
        end
        if (in_valid_reg && stage_ready) begin
            term_reg <= term_next;
        end
    end

endmodule

@@ hdl/msac_acc.sv @@
module msac_acc #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  msac_pkg::cfg_t      cfg,
    input  logic                term_valid,
    output logic                term_ready,
    input  msac_pkg::term_t     term,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [12:0]         m_inlier_count,
    output logic signed [28:0]  m_score,
    output logic                m_stopped_early,
    output logic [12:0]         m_points_tested
);

    localparam int PW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int CW = (NW > 13) ? NW : 13;
    localparam int SW = NW + 1;
    localparam int LW = NW + 19;

    logic [PW-1:0]      pos_reg, pos_next;
    logic [12:0]        tally_reg, tally_next;
    logic signed [29:0] loss_reg, loss_next;
    logic signed [29:0] best_reg, best_next;
    logic               fin_reg, fin_next;

    logic               m_valid_reg, m_valid_next;
    logic [12:0]        m_inlier_count_reg;
    logic signed [28:0] m_score_reg;
    logic               m_stopped_early_reg;
    logic [12:0]        m_points_tested_reg;

    logic [CW-1:0]      count_w;
    logic [NW-1:0]      n_eff;
    logic [NW-1:0]      pos_inc;
    logic               last;
    logic signed [30:0] loss_sum;
    logic signed [29:0] loss_upd;
    logic [12:0]        tally_upd;
    logic signed [30:0] score_w;
    logic signed [SW-1:0] span;
    logic signed [LW-1:0] bound;
    logic               stop;
    logic               is_point;
    logic               emit;
    logic               out_free;
    logic               fire;
    logic signed [28:0] score_sat;

    always_comb begin
        count_w = CW'(cfg.points_count);
        if (cfg.points_count == 13'd0) begin
            n_eff = NW'(1);
        end else if (count_w > CW'(MAX_POINTS)) begin
            n_eff = NW'(MAX_POINTS);
        end else begin
            n_eff = count_w[NW-1:0];
        end
        pos_inc = NW'(pos_reg) + NW'(1);
        last    = pos_inc >= n_eff;

        tally_upd = (term.inlier && tally_reg != msac_pkg::TALLY_MAX)
                  ? tally_reg + 13'd1 : tally_reg;
        loss_sum  = 31'(loss_reg) - 31'($signed({1'b0, term.loss_term}));
        if (!term.in_norm) begin
            loss_upd = loss_reg;
        end else if (loss_sum < 31'(msac_pkg::LOSS_MIN)) begin
            loss_upd = msac_pkg::LOSS_MIN;
        end else begin
            loss_upd = loss_sum[29:0];
        end

        if (cfg.mode == msac_pkg::MODE_MSAC) begin
            score_w = 31'(loss_upd);
        end else begin
            score_w = -$signed({2'b00, tally_upd, 16'h0000});
        end

        // best case for the rest: every remaining point adds a full -1.0
        span  = $signed({1'b0, n_eff}) - $signed({1'b0, NW'(pos_reg)});
        bound = LW'(score_w) - (LW'(span) <<< 16);
        stop  = bound > LW'(best_reg);

        score_sat = (score_w < 31'(msac_pkg::SCORE_MIN)) ? msac_pkg::SCORE_MIN
                                                          : score_w[28:0];

        is_point   = term.cmd == msac_pkg::CMD_POINT;
        emit       = is_point && !fin_reg && (last || stop);
        out_free   = !m_valid_reg || m_ready;
        term_ready = !emit || out_free;
        fire       = term_valid && term_ready;
    end

    always_comb begin
        pos_next   = pos_reg;
        tally_next = tally_reg;
        loss_next  = loss_reg;
        best_next  = best_reg;
        fin_next   = fin_reg;
        if (fire) begin
            if (!is_point) begin
                if (term.offered_score < best_reg) begin
                    best_next = term.offered_score;
                end
            end else if (last) begin
                pos_next   = '0;
                tally_next = '0;
                loss_next  = '0;
                fin_next   = 1'b0;
            end else begin
                pos_next = PW'(pos_inc);
                if (!fin_reg) begin
                    tally_next = tally_upd;
                    loss_next  = loss_upd;
                    fin_next   = stop;
                end
            end
        end
    end

    always_comb begin
        if (fire && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            tally_reg   <= '0;
            loss_reg    <= '0;
            best_reg    <= msac_pkg::BEST_RESET;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            tally_reg   <= tally_next;
            loss_reg    <= loss_next;
            best_reg    <= best_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            m_inlier_count_reg  <= tally_upd;
            m_score_reg         <= score_sat;
            m_stopped_early_reg <= !last;
            m_points_tested_reg <= 13'(pos_inc);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_inlier_count  = m_inlier_count_reg;
    assign m_score         = m_score_reg;
    assign m_stopped_early = m_stopped_early_reg;
    assign m_points_tested = m_points_tested_reg;

endmodule

@@ hdl/msac_checker.sv @@
module msac_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [12:0]        m_inlier_count,
    input logic signed [28:0] m_score,
    input logic               m_stopped_early,
    input logic [12:0]        m_points_tested
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_score)
            && $stable(m_inlier_count) && $stable(m_points_tested)
            && $stable(m_stopped_early))
        else $error("result beat changed while stalled");

    a_reset_drop: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("outputs not idle after reset");

    a_inliers_le_points: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_inlier_count <= m_points_tested)
        else $error("more inliers than points tested");

    a_score_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_inlier_count == 13'd0 && !m_stopped_early |-> m_score <= 29'sd0)
        else $error("positive score on result");

endmodule

bind ransac_msac_hypothesis_scorer_unit msac_checker u_msac_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_inlier_count  (m_inlier_count),
    .m_score         (m_score),
    .m_stopped_early (m_stopped_early),
    .m_points_tested (m_points_tested)
);
